@@ hw/rtl/thumbdec_pkg.sv @@
// ---------------------------------------------------------------------------
// thumbdec_pkg
// Shared types and format codes for the Thumb instruction decoder.
// ---------------------------------------------------------------------------
package thumbdec_pkg;

    localparam int InWidth  = 64;
    localparam int OutWidth = 80;

    localparam logic [4:0] FMT_NONE    = 5'd0;
    localparam logic [4:0] FMT_ADD_SP  = 5'd1;
    localparam logic [4:0] FMT_SWI     = 5'd2;
    localparam logic [4:0] FMT_ALU     = 5'd3;
    localparam logic [4:0] FMT_HIREG   = 5'd4;
    localparam logic [4:0] FMT_PUSHPOP = 5'd5;
    localparam logic [4:0] FMT_ADDSUB  = 5'd6;
    localparam logic [4:0] FMT_LDR_PC  = 5'd7;
    localparam logic [4:0] FMT_LS_REG  = 5'd8;
    localparam logic [4:0] FMT_LS_SGN  = 5'd9;
    localparam logic [4:0] FMT_B       = 5'd10;
    localparam logic [4:0] FMT_LS_HALF = 5'd11;
    localparam logic [4:0] FMT_LS_SP   = 5'd12;
    localparam logic [4:0] FMT_ADR     = 5'd13;
    localparam logic [4:0] FMT_LDM     = 5'd14;
    localparam logic [4:0] FMT_BCOND   = 5'd15;
    localparam logic [4:0] FMT_BL      = 5'd16;
    localparam logic [4:0] FMT_SHIFT   = 5'd17;
    localparam logic [4:0] FMT_IMM8    = 5'd18;
    localparam logic [4:0] FMT_LS_IMM  = 5'd19;

    localparam logic [1:0] HIOP_BX   = 2'd3;
    localparam logic [3:0] COND_NV   = 4'hE;
    localparam logic [2:0] LEN_SHORT = 3'd2;
    localparam logic [2:0] LEN_LONG  = 3'd4;
    localparam logic [3:0] REG_SP    = 4'd13;
    localparam logic [4:0] BL_SUFFIX = 5'h1F;

    typedef struct packed {
        logic        mode_switch;
        logic [2:0]  length_bytes;
        logic [31:0] target;
        logic [8:0]  reg_list;
        logic [9:0]  imm_value;
        logic [2:0]  reg_o;
        logic [3:0]  reg_s;
        logic [3:0]  reg_d;
        logic [3:0]  sub_op;
        logic [4:0]  format_code;
        logic        valid_res;
    } dec_res_t;

endpackage

@@ hw/rtl/thumbdec_decode.sv @@
// ---------------------------------------------------------------------------
// thumbdec_decode
// Format classification, field extraction and branch target for one instruction (a halfword or a BL pair).
// ---------------------------------------------------------------------------
module thumbdec_decode (
    input  logic [31:0]            instr_pair,
    input  logic [31:0]            pc_value,
    output thumbdec_pkg::dec_res_t res
);
    import thumbdec_pkg::*;

    logic [15:0] h;
    logic [15:0] nx;
    logic [7:0]  hb;
    logic        ok;
    logic        tgt_en;
    logic [31:0] off;
    dec_res_t    r;

    assign h   = instr_pair[15:0];
    assign nx  = instr_pair[31:16];
    assign hb  = h[15:8];

    always_comb begin
        r              = '0;
        r.length_bytes = LEN_SHORT;
        ok             = 1'b1;
        tgt_en         = 1'b0;
        off            = '0;
        if (hb == 8'hB0) begin
            r.format_code = FMT_ADD_SP;
            r.sub_op      = {3'b0, h[7]};
            r.reg_d       = REG_SP;
            r.imm_value   = {1'b0, h[6:0], 2'b0};
        end else if (hb == 8'hDF) begin
            r.format_code = FMT_SWI;
            r.imm_value   = {2'b0, h[7:0]};
        end else if ((hb & 8'hFC) == 8'h40) begin
            r.format_code = FMT_ALU;
            r.sub_op      = h[9:6];
            r.reg_s       = {1'b0, h[5:3]};
            r.reg_d       = {1'b0, h[2:0]};
        end else if ((hb & 8'hFC) == 8'h44) begin
            r.format_code = FMT_HIREG;
            r.sub_op      = {2'b0, h[9:8]};
            r.reg_s       = {h[6], h[5:3]};
            if (h[9:8] == HIOP_BX) begin
                if (h[7]) begin
                    ok = 1'b0;
                end else begin
                    r.mode_switch = 1'b1;
                end
            end else begin
                if (!h[7] && !h[6]) begin
                    ok = 1'b0;
                end
                r.reg_d = {h[7], h[2:0]};
            end
        end else if ((hb & 8'hF6) == 8'hB4) begin
            r.format_code = FMT_PUSHPOP;
            r.sub_op      = {3'b0, h[11]};
            r.reg_d       = REG_SP;
            r.reg_list    = h[8:0];
        end else if ((hb & 8'hF8) == 8'h18) begin
            r.format_code = FMT_ADDSUB;
            r.sub_op      = {2'b0, h[10:9]};
            r.reg_s       = {1'b0, h[5:3]};
            r.reg_d       = {1'b0, h[2:0]};
            if (h[10]) begin
                r.imm_value = {7'b0, h[8:6]};
            end else begin
                r.reg_o = h[8:6];
            end
        end else if ((hb & 8'hF8) == 8'h48) begin
            r.format_code = FMT_LDR_PC;
            r.reg_d       = {1'b0, h[10:8]};
            r.imm_value   = {h[7:0], 2'b0};
        end else if ((hb & 8'hF2) == 8'h50 || (hb & 8'hF2) == 8'h52) begin
            r.format_code = h[9] ? FMT_LS_SGN : FMT_LS_REG;
            r.sub_op      = {2'b0, h[11:10]};
            r.reg_o       = h[8:6];
            r.reg_s       = {1'b0, h[5:3]};
            r.reg_d       = {1'b0, h[2:0]};
        end else if ((hb & 8'hF8) == 8'hE0) begin
            r.format_code = FMT_B;
            tgt_en        = 1'b1;
            off           = {{20{h[10]}}, h[10:0], 1'b0};
        end else if ((hb & 8'hF0) == 8'h80) begin
            r.format_code = FMT_LS_HALF;
            r.sub_op      = {3'b0, h[11]};
            r.imm_value   = {4'b0, h[10:6], 1'b0};
            r.reg_s       = {1'b0, h[5:3]};
            r.reg_d       = {1'b0, h[2:0]};
        end else if ((hb & 8'hF0) == 8'h90) begin
            r.format_code = FMT_LS_SP;
            r.sub_op      = {3'b0, h[11]};
            r.reg_d       = {1'b0, h[10:8]};
            r.imm_value   = {h[7:0], 2'b0};
        end else if ((hb & 8'hF0) == 8'hA0) begin
            r.format_code = FMT_ADR;
            r.sub_op      = {3'b0, h[11]};
            r.reg_d       = {1'b0, h[10:8]};
            r.imm_value   = {h[7:0], 2'b0};
            tgt_en        = !h[11];
            off           = {22'b0, h[7:0], 2'b0};
        end else if ((hb & 8'hF0) == 8'hC0) begin
            r.format_code = FMT_LDM;
            r.sub_op      = {3'b0, h[11]};
            r.reg_d       = {1'b0, h[10:8]};
            r.reg_list    = {1'b0, h[7:0]};
        end else if ((hb & 8'hF0) == 8'hD0) begin
            r.format_code = FMT_BCOND;
            r.sub_op      = h[11:8];
            if (h[11:8] == COND_NV) begin
                ok = 1'b0;
            end else begin
                tgt_en = 1'b1;
                off    = {{23{h[7]}}, h[7:0], 1'b0};
            end
        end else if ((hb & 8'hF0) == 8'hF0) begin
            r.format_code = FMT_BL;
            if (h[11] || nx[15:11] != BL_SUFFIX) begin
                ok = 1'b0;
            end else begin
                tgt_en         = 1'b1;
                off            = {{9{h[10]}}, h[10:0], nx[10:0], 1'b0};
                r.length_bytes = LEN_LONG;
            end
        end else if ((hb & 8'hE0) == 8'h00) begin
            r.format_code = FMT_SHIFT;
            r.sub_op      = {2'b0, h[12:11]};
            r.imm_value   = {5'b0, h[10:6]};
            r.reg_s       = {1'b0, h[5:3]};
            r.reg_d       = {1'b0, h[2:0]};
        end else if ((hb & 8'hE0) == 8'h20) begin
            r.format_code = FMT_IMM8;
            r.sub_op      = {2'b0, h[12:11]};
            r.reg_d       = {1'b0, h[10:8]};
            r.imm_value   = {2'b0, h[7:0]};
        end else if ((hb & 8'hE0) == 8'h60) begin
            r.format_code = FMT_LS_IMM;
            r.sub_op      = {2'b0, h[12:11]};
            r.imm_value   = h[12] ? {5'b0, h[10:6]} : {3'b0, h[10:6], 2'b0};
            r.reg_s       = {1'b0, h[5:3]};
            r.reg_d       = {1'b0, h[2:0]};
        end else begin
            ok = 1'b0;
        end

        if (tgt_en) begin
            r.target = pc_value + 32'd4 + off;
        end
        if (!ok) begin
            r              = '0;
            r.format_code  = FMT_NONE;
            r.length_bytes = LEN_SHORT;
        end
        r.valid_res = ok;
        res         = r;
    end

endmodule

@@ hw/rtl/thumb_instruction_decoder_top.sv @@
// ---------------------------------------------------------------------------
// thumb_instruction_decoder_top
// Streaming ARMv4T Thumb decoder: input register, decode, result register.
// ---------------------------------------------------------------------------
// Each request carries a halfword pair and its PC and yields one result via the
// input register, the decode and branch-target adder, and the result register.
// One request is taken per clock while s_tready is high; the two registers form
// a two-stage pipeline and, once both are full, hold while m_tready is low.
module thumb_instruction_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // instr_pair[31:0], pc_value[63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // valid_res[0], format_code[5:1], sub_op[9:6],
                                   // reg_d[13:10], reg_s[17:14], reg_o[20:18],
                                   // imm_value[30:21], reg_list[39:31],
                                   // target[71:40], length_bytes[74:72],
                                   // mode_switch[75], zero pad[79:76]
);
    import thumbdec_pkg::*;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [InWidth-1:0] in_data_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    dec_res_t          out_res_reg;
    dec_res_t          dec_res;
    logic              out_open;
    logic              advance;

    assign out_open = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_open;
    assign s_tready = !in_valid_reg || out_open;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = out_open ? in_valid_reg : out_valid_reg;

    thumbdec_decode u_decode (
        .instr_pair (in_data_reg[31:0]),
        .pc_value   (in_data_reg[63:32]),
        .res        (dec_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
        if (advance) begin
            out_res_reg <= dec_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OutWidth - $bits(dec_res_t))'(0), out_res_reg};

`ifndef SYNTH
    a_invalid_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[5:1] == FMT_NONE && m_tdata[74:72] == LEN_SHORT)
        else $error("invalid result carries a format or length");

    a_long_is_bl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[74:72] == LEN_LONG |-> m_tdata[5:1] == FMT_BL)
        else $error("four-byte length outside a BL pair");

    a_bx_fmt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[75] |-> m_tdata[5:1] == FMT_HIREG && m_tdata[0])
        else $error("mode switch outside a valid BX");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("decoded request lost before the result register");
`endif

endmodule
